// ----- design/gst_pkg.sv -----
// Shared constants, codes and control types for the generational slot table.
package gst_pkg;

  localparam int OP_W     = 2;
  localparam int HIDX_W   = 8;
  localparam int GEN_W    = 32;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int RIDX_W   = 6;

  localparam int SLOTS_DEF     = 64;
  localparam int DATA_BITS_DEF = 32;

  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

  localparam logic [GEN_W-1:0] GEN_FIRST = 32'd1;

  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

endpackage

// ----- design/gst_if.sv -----
// Request and response channel interfaces of the generational slot table.
interface gst_req_if;
  logic                         valid;
  logic                         ready;
  logic [gst_pkg::OP_W-1:0]     operation;
  logic [gst_pkg::HIDX_W-1:0]   handle_index;
  logic [gst_pkg::GEN_W-1:0]    handle_generation;
  logic [gst_pkg::WORD_W-1:0]   payload_in;

  modport source (output valid, operation, handle_index, handle_generation, payload_in,
                  input ready);
  modport sink (input valid, operation, handle_index, handle_generation, payload_in,
                output ready);
endinterface

interface gst_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [gst_pkg::STATUS_W-1:0] status;
  logic [gst_pkg::RIDX_W-1:0]   result_index;
  logic [gst_pkg::GEN_W-1:0]    result_generation;
  logic [gst_pkg::WORD_W-1:0]   payload_out;

  modport source (output valid, status, result_index, result_generation, payload_out,
                  input ready);
  modport sink (input valid, status, result_index, result_generation, payload_out,
                output ready);
endinterface

// ----- design/gst_ctrl.sv -----
// Controller: capture and execute sequencing plus the response word flag.
module gst_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output gst_pkg::cmd_t cmd
);
  import gst_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic valid_next;
  logic accept;
  logic commit;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign commit   = (state == S_EXEC) && (!out_valid || out_ready);

  assign cmd.capture = accept;
  assign cmd.commit  = commit;

  always_comb begin
    case (state)
      S_IDLE:  state_next = accept ? S_EXEC : S_IDLE;
      S_EXEC:  state_next = commit ? S_IDLE : S_EXEC;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (commit) begin
      valid_next = 1'b1;
    end else if (out_ready) begin
      valid_next = 1'b0;
    end else begin
      valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= valid_next;
    end
  end

endmodule

// ----- design/gst_datapath.sv -----
// Datapath: slot memories, occupancy bits, free-slot encoder and response register.
module gst_datapath #(
  parameter int SLOTS     = gst_pkg::SLOTS_DEF,
  parameter int DATA_BITS = gst_pkg::DATA_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  gst_pkg::cmd_t                cmd,
  input  logic [gst_pkg::OP_W-1:0]     operation,
  input  logic [gst_pkg::HIDX_W-1:0]   handle_index,
  input  logic [gst_pkg::GEN_W-1:0]    handle_generation,
  input  logic [gst_pkg::WORD_W-1:0]   payload_in,
  output logic [gst_pkg::STATUS_W-1:0] status,
  output logic [gst_pkg::RIDX_W-1:0]   result_index,
  output logic [gst_pkg::GEN_W-1:0]    result_generation,
  output logic [gst_pkg::WORD_W-1:0]   payload_out
);
  import gst_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [GEN_W-1:0]     gen_mem [SLOTS];
  logic [DATA_BITS-1:0] pay_mem [SLOTS];
  logic [SLOTS-1:0]     used;
  logic [SLOTS-1:0]     gen_init;

  logic [OP_W-1:0]      op_q;
  logic [IDX_W-1:0]     slot_q;
  logic                 in_range_q;
  logic [GEN_W-1:0]     hgen_q;
  logic [DATA_BITS-1:0] data_q;
  logic                 full_q;
  logic [GEN_W-1:0]     gen_rd;
  logic                 gen_init_rd;
  logic [DATA_BITS-1:0] pay_rd;

  logic [SLOTS-1:0]     free_vec;
  logic [SLOTS-1:0]     free_low;
  logic [IDX_W-1:0]     free_idx;
  logic [IDX_W-1:0]     rd_addr;

  logic [GEN_W-1:0]     gen_cur;
  logic [GEN_W-1:0]     gen_inc;
  logic [GEN_W-1:0]     gen_wrap;
  logic                 hit;
  logic [HIDX_W-1:0]    slot_ext;
  logic [STATUS_W-1:0]  st_next;
  logic [RIDX_W-1:0]    ridx_next;
  logic [GEN_W-1:0]     rgen_next;
  logic [WORD_W-1:0]    pay_next;
  logic                 wr_alloc;
  logic                 wr_free;

  // lowest free slot: isolate lowest set bit, then OR-encode
  assign free_vec = ~used;
  assign free_low = free_vec & (~free_vec + {{(SLOTS-1){1'b0}}, 1'b1});

  always_comb begin
    free_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (free_low[i]) begin
        free_idx = free_idx | IDX_W'(i);
      end
    end
  end

  assign rd_addr = (operation == OP_ALLOC) ? free_idx : handle_index[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q        <= operation;
      slot_q      <= rd_addr;
      in_range_q  <= ({1'b0, handle_index} < (HIDX_W+1)'(SLOTS));
      hgen_q      <= handle_generation;
      data_q      <= DATA_BITS'(payload_in);
      full_q      <= ~(|free_vec);
      gen_rd      <= gen_mem[rd_addr];
      gen_init_rd <= gen_init[rd_addr];
      pay_rd      <= pay_mem[rd_addr];
    end
  end

  assign gen_cur  = gen_init_rd ? gen_rd : GEN_FIRST;
  assign gen_inc  = gen_cur + GEN_FIRST;
  assign gen_wrap = (gen_inc == '0) ? GEN_FIRST : gen_inc;
  assign hit      = in_range_q && (hgen_q != '0) && used[slot_q] && (gen_cur == hgen_q);
  assign slot_ext = HIDX_W'(slot_q);

  always_comb begin
    st_next   = ST_BAD;
    ridx_next = '0;
    rgen_next = '0;
    pay_next  = '0;
    wr_alloc  = 1'b0;
    wr_free   = 1'b0;
    case (op_q)
      OP_ALLOC: begin
        if (full_q) begin
          st_next = ST_FULL;
        end else begin
          st_next   = ST_OK;
          ridx_next = slot_ext[RIDX_W-1:0];
          rgen_next = gen_cur;
          wr_alloc  = 1'b1;
        end
      end
      OP_LOOKUP: begin
        if (hit) begin
          st_next  = ST_OK;
          pay_next = WORD_W'(pay_rd);
        end
      end
      OP_FREE: begin
        if (hit) begin
          st_next = ST_OK;
          wr_free = 1'b1;
        end
      end
      default: st_next = ST_BAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_alloc) begin
      pay_mem[slot_q] <= data_q;
    end
    if (cmd.commit && wr_free) begin
      gen_mem[slot_q] <= gen_wrap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used     <= '0;
      gen_init <= '0;
    end else if (cmd.commit) begin
      if (wr_alloc) begin
        used[slot_q] <= 1'b1;
      end
      if (wr_free) begin
        used[slot_q]     <= 1'b0;
        gen_init[slot_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status            <= st_next;
      result_index      <= ridx_next;
      result_generation <= rgen_next;
      payload_out       <= pay_next;
    end
  end

endmodule

// ----- design/generational_slot_table.sv -----
// Top level of the generational slot table: controller and datapath.
//
//   channel  dir  fields
//   req      in   operation, handle_index, handle_generation, payload_in
//   rsp      out  status, result_index, result_generation, payload_out
//
// Each word is handled as capture, with a registered read of the slot
// memories, then check, write back and load the response register.
// The response register frees the request side; a stalled response holds
// the next word in the execute cycle until the register is taken.
// Synchronous reset clears occupancy and generation-valid bits; no sweep.
module generational_slot_table #(
  parameter int SLOTS     = gst_pkg::SLOTS_DEF,
  parameter int DATA_BITS = gst_pkg::DATA_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  gst_req_if.sink    req,
  gst_rsp_if.source  rsp
);
  import gst_pkg::*;

  cmd_t cmd;

  gst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  gst_datapath #(
    .SLOTS     (SLOTS),
    .DATA_BITS (DATA_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .operation         (req.operation),
    .handle_index      (req.handle_index),
    .handle_generation (req.handle_generation),
    .payload_in        (req.payload_in),
    .status            (rsp.status),
    .result_index      (rsp.result_index),
    .result_generation (rsp.result_generation),
    .payload_out       (rsp.payload_out)
  );

endmodule

// ----- sim/tb_generational_slot_table.sv -----
// Self-checking testbench for the generational slot table: directed and random traffic.
module tb_generational_slot_table;
  import gst_pkg::*;

  localparam int SLOTS          = SLOTS_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_GAP        = 40;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [RIDX_W-1:0]   index;
    logic [GEN_W-1:0]    generation;
    logic [WORD_W-1:0]   payload;
  } slot_result_t;

  logic clk;
  logic rst;

  gst_req_if req_ch ();
  gst_rsp_if rsp_ch ();

  generational_slot_table u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // shadow copy of the slot table
  bit                slot_busy [SLOTS];
  logic [GEN_W-1:0]  slot_gen  [SLOTS];
  logic [WORD_W-1:0] slot_data [SLOTS];

  slot_result_t pending_results[$];
  int           mismatch_count;
  int           quiet_cycles;
  int           send_idle_pct;
  int           stall_pct;
  bit           long_hold_pending;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic slot_result_t predict_slot_op(input logic [OP_W-1:0] op,
                                                   input logic [HIDX_W-1:0] idx,
                                                   input logic [GEN_W-1:0] gen,
                                                   input logic [WORD_W-1:0] data);
    slot_result_t r;
    bit           hit;
    r        = '0;
    r.status = ST_BAD;
    hit = (gen != '0) && (idx < SLOTS) && slot_busy[idx] && (slot_gen[idx] == gen);
    case (op)
      OP_ALLOC: begin
        r.status = ST_FULL;
        for (int k = 0; k < SLOTS; k++) begin
          if (!slot_busy[k]) begin
            if (slot_gen[k] == '0) slot_gen[k] = GEN_FIRST;
            slot_data[k] = data;
            slot_busy[k] = 1'b1;
            r.status     = ST_OK;
            r.index      = RIDX_W'(k);
            r.generation = slot_gen[k];
            break;
          end
        end
      end
      OP_LOOKUP: begin
        if (hit) begin
          r.status  = ST_OK;
          r.payload = slot_data[idx];
        end
      end
      OP_FREE: begin
        if (hit) begin
          slot_gen[idx] = slot_gen[idx] + 1'b1;
          if (slot_gen[idx] == '0) slot_gen[idx] = GEN_FIRST;
          slot_busy[idx] = 1'b0;
          r.status       = ST_OK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, want %h", $realtime, field, got, want);
    mismatch_count++;
  endtask

  task automatic send_word(input logic [OP_W-1:0] op, input logic [HIDX_W-1:0] idx,
                           input logic [GEN_W-1:0] gen, input logic [WORD_W-1:0] data);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid             <= 1'b1;
    req_ch.operation         <= op;
    req_ch.handle_index      <= idx;
    req_ch.handle_generation <= gen;
    req_ch.payload_in        <= data;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    pending_results.push_back(predict_slot_op(op, idx, gen, data));
  endtask

  // mostly live handles, the rest stale, wrong-generation, zeroed, out of range or on free slots
  task automatic pick_handle(output logic [HIDX_W-1:0] idx, output logic [GEN_W-1:0] gen);
    int live[$];
    int spare[$];
    int k;
    for (int s = 0; s < SLOTS; s++) begin
      if (slot_busy[s]) live.push_back(s);
      else spare.push_back(s);
    end
    k = $urandom_range(SLOTS - 1);
    if (live.size() > 0 && $urandom_range(99) < 75) begin
      k   = live[$urandom_range(live.size() - 1)];
      idx = HIDX_W'(k);
      gen = slot_gen[k];
    end else begin
      case ($urandom_range(5))
        0: begin
          idx = HIDX_W'(k);
          gen = '0;
        end
        1: begin
          idx = HIDX_W'($urandom_range(255, SLOTS));
          gen = $urandom;
        end
        2: begin
          if (spare.size() > 0) k = spare[$urandom_range(spare.size() - 1)];
          idx = HIDX_W'(k);
          gen = slot_gen[k];
        end
        3: begin
          idx = HIDX_W'(k);
          gen = slot_gen[k] - 1'b1;
        end
        4: begin
          idx = HIDX_W'(k);
          gen = slot_gen[k] + 1'b1;
        end
        default: begin
          idx = HIDX_W'(k);
          gen = $urandom;
        end
      endcase
    end
  endtask

  task automatic send_random_word(input int alloc_pct);
    logic [HIDX_W-1:0] idx;
    logic [GEN_W-1:0]  gen;
    int                roll;
    roll = $urandom_range(99);
    pick_handle(idx, gen);
    if (roll < 3)
      send_word(OP_UNUSED, HIDX_W'($urandom), $urandom, $urandom);
    else if (roll < 3 + alloc_pct)
      send_word(OP_ALLOC, HIDX_W'($urandom), $urandom, $urandom);
    else if (roll[0])
      send_word(OP_LOOKUP, idx, gen, $urandom);
    else
      send_word(OP_FREE, idx, gen, $urandom);
  endtask

  task automatic test_directed_cases();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_word(OP_LOOKUP, 8'd0, 32'd1, 32'h0);
    send_word(OP_ALLOC, 8'd0, 32'd0, 32'hFFFF_FFFF);
    send_word(OP_ALLOC, 8'hFF, 32'hFFFF_FFFF, 32'h0);
    send_word(OP_LOOKUP, 8'd0, 32'd1, 32'h0);
    send_word(OP_LOOKUP, 8'd1, 32'd1, 32'hFFFF_FFFF);
    send_word(OP_LOOKUP, 8'd0, 32'd0, 32'h0);
    send_word(OP_LOOKUP, 8'd255, 32'd1, 32'h0);
    send_word(OP_LOOKUP, 8'd64, 32'd1, 32'h0);
    send_word(OP_FREE, 8'd1, 32'hFFFF_FFFF, 32'h0);
    send_word(OP_FREE, 8'd0, 32'd2, 32'h0);
    send_word(OP_FREE, 8'd0, 32'd0, 32'h0);
    send_word(OP_FREE, 8'd64, 32'd1, 32'h0);
    send_word(OP_FREE, 8'd0, 32'd1, 32'h0);
    send_word(OP_FREE, 8'd0, 32'd1, 32'h0);
    send_word(OP_LOOKUP, 8'd0, 32'd1, 32'h0);
    send_word(OP_ALLOC, 8'd0, 32'd0, 32'hA5A5_A5A5);
    send_word(OP_LOOKUP, 8'd0, 32'd2, 32'h0);
    send_word(OP_UNUSED, 8'd0, 32'd2, 32'hFFFF_FFFF);
    send_word(OP_LOOKUP, 8'd0, 32'd2, 32'h0);
  endtask

  task automatic test_fill_to_full();
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (SLOTS + 2) send_word(OP_ALLOC, HIDX_W'($urandom), $urandom, $urandom);
    send_word(OP_FREE, 8'd5, slot_gen[5], $urandom);
    send_word(OP_FREE, 8'd40, slot_gen[40], $urandom);
    send_word(OP_LOOKUP, 8'd5, slot_gen[5] - 1'b1, $urandom);
    send_word(OP_ALLOC, HIDX_W'($urandom), $urandom, $urandom);
    send_word(OP_ALLOC, HIDX_W'($urandom), $urandom, $urandom);
    send_word(OP_ALLOC, HIDX_W'($urandom), $urandom, $urandom);
    send_word(OP_LOOKUP, 8'd40, slot_gen[40], $urandom);
  endtask

  task automatic test_random_traffic(input int count, input int idle_pct,
                                     input int stall_arg, input int alloc_pct);
    send_idle_pct = idle_pct;
    stall_pct     = stall_arg;
    repeat (count) send_random_word(alloc_pct);
  endtask

  // response side held off while requests keep coming, so the input backs up
  task automatic test_backpressure();
    send_idle_pct     = 0;
    stall_pct         = 0;
    long_hold_pending = 1'b1;
    repeat (30) send_random_word(40);
  endtask

  always begin
    @(negedge clk);
    if (long_hold_pending) begin
      long_hold_pending = 1'b0;
      rsp_ch.ready <= 1'b0;
      repeat (LONG_HOLD) @(negedge clk);
    end
    rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin : result_check
    slot_result_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word, status", 32'(rsp_ch.status), 32'hx);
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.status !== want.status)
          report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
        if (rsp_ch.result_index !== want.index)
          report_mismatch("result_index", 32'(rsp_ch.result_index), 32'(want.index));
        if (rsp_ch.result_generation !== want.generation)
          report_mismatch("result_generation", rsp_ch.result_generation, want.generation);
        if (rsp_ch.payload_out !== want.payload)
          report_mismatch("payload_out", rsp_ch.payload_out, want.payload);
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
        (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("generational_slot_table verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst                      = 1'b1;
    req_ch.valid             = 1'b0;
    req_ch.operation         = '0;
    req_ch.handle_index      = '0;
    req_ch.handle_generation = '0;
    req_ch.payload_in        = '0;
    rsp_ch.ready             = 1'b0;
    mismatch_count           = 0;
    quiet_cycles             = 0;
    send_idle_pct            = 0;
    stall_pct                = 0;
    long_hold_pending        = 1'b0;
    for (int s = 0; s < SLOTS; s++) begin
      slot_busy[s] = 1'b0;
      slot_gen[s]  = GEN_FIRST;
      slot_data[s] = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_fill_to_full();
    test_random_traffic(420, 0, 0, 35);
    test_random_traffic(400, 76, 0, 55);
    test_random_traffic(400, 0, 76, 30);
    test_random_traffic(400, 26, 26, 45);
    test_backpressure();

    @(negedge clk);
    req_ch.valid <= 1'b0;
    stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("generational_slot_table verification clean");
    end else begin
      $display("generational_slot_table verification failed");
    end
    $finish;
  end

endmodule
